### rtl/core/timestamped_event_queue_defines.svh
// assertion macros used by the event queue checker
`ifndef TIMESTAMPED_EVENT_QUEUE_DEFINES_SVH
`define TIMESTAMPED_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define TEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define TEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// what must hold in the cycle after a reset edge
`define TEQ_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### rtl/core/teq_pkg.sv
// types and constants of the timestamped event queue
package teq_pkg;

  localparam int PTR_W      = 12;
  localparam int NUM_W      = 7;
  localparam int CMDQ_DEPTH = 2;

  localparam int SEC_W   = 23;
  localparam int MICRO_W = 20;
  localparam int REM_W   = 10;

  localparam int                    TICKS_PER_SEC = 1000;
  localparam int                    RECIP_W       = 29;
  localparam logic [RECIP_W-1:0]    SEC_RECIP     = 29'd274877907;
  localparam int                    SEC_SHIFT     = 38;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_POLL = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_EVENT    = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_INVALID  = 3'd4,
    ST_POLL     = 3'd5
  } status_t;

  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_kind_t;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_DRAIN = 1'b1
  } back_state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [1:0]         device;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic [31:0]        now_ms;
    logic [4:0]         read_count;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 pending;
    logic [SEC_W-1:0]     stamp_seconds;
    logic [MICRO_W-1:0]   stamp_micros;
    logic [15:0]          out_type;
    logic [15:0]          out_code;
    logic signed [31:0]   out_value;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic [15:0]        etype;
    logic [15:0]        ecode;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    cmd_kind_t        kind;
    status_t          status;
    logic             pending;
    logic [1:0]       device;
    logic [PTR_W-1:0] ptr;
    logic [NUM_W-1:0] num;
    logic             drains;
  } cmd_t;

  typedef struct packed {
    status_t status;
    logic    pending;
    logic    last;
  } side_t;

endpackage

### rtl/core/teq_ram.sv
// generic single write port ram with registered read
module teq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/teq_cmd_fifo.sv
// short command queue between the front and back parts
module teq_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  teq_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output teq_pkg::cmd_t head
);

  localparam int IW = $clog2(teq_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(teq_pkg::CMDQ_DEPTH + 1);

  teq_pkg::cmd_t slot_r [teq_pkg::CMDQ_DEPTH];
  logic [IW-1:0] wr_r;
  logic [IW-1:0] rd_r;
  logic [CW-1:0] cnt_r;

  assign full       = (cnt_r == CW'(teq_pkg::CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = slot_r[rd_r];

  // ring index step, depth need not be a power of two
  function automatic logic [IW-1:0] step(input logic [IW-1:0] idx);
    logic [IW-1:0] nxt;
    nxt = (idx == IW'(teq_pkg::CMDQ_DEPTH - 1)) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= step(wr_r);
      end
      if (pop && head_valid) begin
        rd_r <= step(rd_r);
      end
      priority if ((push && !full) && !(pop && head_valid)) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!(push && !full) && (pop && head_valid)) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/teq_front.sv
// front part: classifies requests, keeps the queue pointers, writes pushed events
module teq_front #(
  parameter int QUEUE_DEPTH  = 128,
  parameter int DEVICE_COUNT = 2,
  parameter int MAX_READ     = 16,
  localparam int AW = $clog2(DEVICE_COUNT * QUEUE_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  teq_pkg::in_item_t in_data,
  output logic              cmd_push,
  output teq_pkg::cmd_t     cmd_data,
  input  logic              cmd_full,
  input  logic              read_done,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output teq_pkg::entry_t   ram_wdata
);

  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int DW  = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int CW  = $clog2(MAX_READ + 1);
  localparam int MW0 = (PW > CW) ? PW : CW;
  localparam int MW  = ((MW0 > 5) ? MW0 : 5) + 1;
  localparam int OW  = $clog2(teq_pkg::CMDQ_DEPTH + 2);

  logic [PW-1:0] wp_r [DEVICE_COUNT];
  logic [PW-1:0] rp_r [DEVICE_COUNT];
  logic [OW-1:0] outst_r;
  logic [OW-1:0] outst_nxt;

  logic          accept;
  logic          dev_ok;
  logic [DW-1:0] dev_idx;
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp_step;
  logic          full;
  logic          empty;
  logic [MW-1:0] occ;
  logic [MW-1:0] sat;
  logic [MW-1:0] rd_num;
  logic          rd_drains;
  logic [MW-1:0] rp_sum;
  logic [PW-1:0] rp_adv;
  logic          write_ok;
  logic          read_go;

  // pushes wait while a drain still has reads to issue, so no slot is reused early
  assign in_ready = !cmd_full &&
                    !((outst_r != '0) && (in_data.opcode == teq_pkg::OP_PUSH));
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept;

  always_comb begin
    dev_ok  = ({1'b0, in_data.device} < 3'(DEVICE_COUNT));
    dev_idx = dev_ok ? in_data.device[DW-1:0] : '0;
    wp      = wp_r[dev_idx];
    rp      = rp_r[dev_idx];
    wp_step = (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
    full    = (wp_step == rp);
    empty   = (wp == rp);

    if (wp >= rp) begin
      occ = MW'(wp) - MW'(rp);
    end else begin
      occ = MW'(wp) + MW'(QUEUE_DEPTH) - MW'(rp);
    end
    sat       = (MW'(in_data.read_count) > MW'(MAX_READ)) ? MW'(MAX_READ)
                                                         : MW'(in_data.read_count);
    rd_num    = (sat < occ) ? sat : occ;
    rd_drains = (rd_num == occ);
    rp_sum    = MW'(rp) + rd_num;
    rp_adv    = (rp_sum >= MW'(QUEUE_DEPTH)) ? PW'(rp_sum - MW'(QUEUE_DEPTH)) : PW'(rp_sum);

    cmd_data         = '0;
    cmd_data.kind    = teq_pkg::CMD_SINGLE;
    cmd_data.status  = teq_pkg::ST_INVALID;
    cmd_data.pending = 1'b0;
    cmd_data.device  = in_data.device;
    cmd_data.ptr     = teq_pkg::PTR_W'(rp);
    cmd_data.num     = teq_pkg::NUM_W'(rd_num);
    cmd_data.drains  = rd_drains;
    write_ok         = 1'b0;
    read_go          = 1'b0;

    if (dev_ok) begin
      unique case (in_data.opcode)
        teq_pkg::OP_PUSH: begin
          cmd_data.pending = 1'b1;
          if (full) begin
            cmd_data.status = teq_pkg::ST_DROPPED;
          end else begin
            cmd_data.status = teq_pkg::ST_ACCEPTED;
            write_ok        = 1'b1;
          end
        end
        teq_pkg::OP_POLL: begin
          cmd_data.status  = teq_pkg::ST_POLL;
          cmd_data.pending = !empty;
        end
        teq_pkg::OP_READ: begin
          priority if (in_data.read_count == '0) begin
            cmd_data.status = teq_pkg::ST_INVALID;
          end else if (empty) begin
            cmd_data.status = teq_pkg::ST_EMPTY;
          end else begin
            cmd_data.kind    = teq_pkg::CMD_READ;
            cmd_data.status  = teq_pkg::ST_EVENT;
            cmd_data.pending = 1'b1;
            read_go          = 1'b1;
          end
        end
        default: begin
          cmd_data.status = teq_pkg::ST_INVALID;
        end
      endcase
    end

    outst_nxt = outst_r;
    if ((accept && read_go) && !read_done) begin
      outst_nxt = outst_r + 1'b1;
    end else if (!(accept && read_go) && read_done) begin
      outst_nxt = outst_r - 1'b1;
    end
  end

  assign ram_we          = accept && write_ok;
  assign ram_waddr       = AW'(32'(dev_idx) * 32'(QUEUE_DEPTH) + 32'(wp));
  assign ram_wdata.stamp = in_data.now_ms;
  assign ram_wdata.etype = in_data.event_type;
  assign ram_wdata.ecode = in_data.event_code;
  assign ram_wdata.value = in_data.event_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DEVICE_COUNT; d++) begin
        wp_r[d] <= '0;
        rp_r[d] <= '0;
      end
      outst_r <= '0;
    end else begin
      if (accept && write_ok) begin
        wp_r[dev_idx] <= wp_step;
      end
      if (accept && read_go) begin
        rp_r[dev_idx] <= rp_adv;
      end
      outst_r <= outst_nxt;
    end
  end

endmodule

### rtl/core/teq_back.sv
// back part: drains commands, reads stored events, converts stamps, holds the result
module teq_back #(
  parameter int QUEUE_DEPTH  = 128,
  parameter int DEVICE_COUNT = 2,
  localparam int AW = $clog2(DEVICE_COUNT * QUEUE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  teq_pkg::cmd_t      head,
  output logic               pop,
  output logic               read_done,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  teq_pkg::entry_t    ram_rdata,
  output logic               out_valid,
  input  logic               out_ready,
  output teq_pkg::out_item_t out_data
);

  localparam int PW     = $clog2(QUEUE_DEPTH);
  localparam int PROD_W = 32 + teq_pkg::RECIP_W;

  teq_pkg::back_state_t state_r, state_nxt;
  logic [PW-1:0]             ptr_r, ptr_nxt;
  logic [1:0]                dev_r, dev_nxt;
  logic [teq_pkg::NUM_W-1:0] left_r, left_nxt;
  logic                      drains_r, drains_nxt;

  logic          adv;
  logic          iss_valid;
  teq_pkg::side_t iss_side;
  logic [PW-1:0] rd_ptr;
  logic [1:0]    rd_dev;
  logic [PW-1:0] ptr_step;

  logic                       s1_valid_r;
  teq_pkg::side_t             s1_side_r;
  logic                       s2_valid_r;
  teq_pkg::side_t             s2_side_r;
  logic [teq_pkg::SEC_W-1:0]  s2_q_r;
  logic [31:0]                s2_tick_r;
  logic [15:0]                s2_type_r;
  logic [15:0]                s2_code_r;
  logic signed [31:0]         s2_value_r;
  logic                       s3_valid_r;
  teq_pkg::side_t             s3_side_r;
  logic [teq_pkg::SEC_W-1:0]  s3_q_r;
  logic [teq_pkg::REM_W-1:0]  s3_rem_r;
  logic [15:0]                s3_type_r;
  logic [15:0]                s3_code_r;
  logic signed [31:0]         s3_value_r;
  logic                       out_valid_r;
  teq_pkg::out_item_t         out_data_r;

  logic [PROD_W-1:0] prod;
  logic [31:0]       rem_full;
  logic              is_event;

  // whole pipe moves together unless the held result is refused
  assign adv = !out_valid_r || out_ready;

  assign rd_ptr   = (state_r == teq_pkg::BK_IDLE) ? head.ptr[PW-1:0] : ptr_r;
  assign rd_dev   = (state_r == teq_pkg::BK_IDLE) ? head.device : dev_r;
  assign ptr_step = (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign ram_raddr = AW'(32'(rd_dev) * 32'(QUEUE_DEPTH) + 32'(rd_ptr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= teq_pkg::BK_IDLE;
      ptr_r    <= '0;
      dev_r    <= '0;
      left_r   <= '0;
      drains_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      dev_r    <= dev_nxt;
      left_r   <= left_nxt;
      drains_r <= drains_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    ptr_nxt          = ptr_r;
    dev_nxt          = dev_r;
    left_nxt         = left_r;
    drains_nxt       = drains_r;
    pop              = 1'b0;
    read_done        = 1'b0;
    ram_re           = 1'b0;
    iss_valid        = 1'b0;
    iss_side.status  = teq_pkg::ST_EVENT;
    iss_side.pending = 1'b0;
    iss_side.last    = 1'b1;

    unique case (state_r)
      teq_pkg::BK_IDLE: begin
        if (adv && head_valid) begin
          pop       = 1'b1;
          iss_valid = 1'b1;
          if (head.kind == teq_pkg::CMD_SINGLE) begin
            iss_side.status  = head.status;
            iss_side.pending = head.pending;
            iss_side.last    = 1'b1;
          end else begin
            ram_re           = 1'b1;
            iss_side.status  = teq_pkg::ST_EVENT;
            iss_side.last    = (head.num == teq_pkg::NUM_W'(1));
            iss_side.pending = !(iss_side.last && head.drains);
            if (iss_side.last) begin
              read_done = 1'b1;
            end else begin
              state_nxt  = teq_pkg::BK_DRAIN;
              ptr_nxt    = ptr_step;
              dev_nxt    = head.device;
              left_nxt   = head.num - 1'b1;
              drains_nxt = head.drains;
            end
          end
        end
      end
      teq_pkg::BK_DRAIN: begin
        if (adv) begin
          iss_valid        = 1'b1;
          ram_re           = 1'b1;
          iss_side.status  = teq_pkg::ST_EVENT;
          iss_side.last    = (left_r == teq_pkg::NUM_W'(1));
          iss_side.pending = !(iss_side.last && drains_r);
          ptr_nxt          = ptr_step;
          left_nxt         = left_r - 1'b1;
          if (iss_side.last) begin
            read_done = 1'b1;
            state_nxt = teq_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = teq_pkg::BK_IDLE;
      end
    endcase
  end

  // seconds by reciprocal multiply, exact for every 32-bit tick
  assign prod     = PROD_W'(ram_rdata.stamp) * PROD_W'(teq_pkg::SEC_RECIP);
  assign rem_full = s2_tick_r - 32'(s2_q_r) * 32'(teq_pkg::TICKS_PER_SEC);
  assign is_event = (s3_side_r.status == teq_pkg::ST_EVENT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= iss_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r  <= iss_side;
      s2_side_r  <= s1_side_r;
      s2_q_r     <= prod[teq_pkg::SEC_SHIFT +: teq_pkg::SEC_W];
      s2_tick_r  <= ram_rdata.stamp;
      s2_type_r  <= ram_rdata.etype;
      s2_code_r  <= ram_rdata.ecode;
      s2_value_r <= ram_rdata.value;
      s3_side_r  <= s2_side_r;
      s3_q_r     <= s2_q_r;
      s3_rem_r   <= rem_full[teq_pkg::REM_W-1:0];
      s3_type_r  <= s2_type_r;
      s3_code_r  <= s2_code_r;
      s3_value_r <= s2_value_r;

      out_data_r.status        <= s3_side_r.status;
      out_data_r.pending       <= s3_side_r.pending;
      out_data_r.last          <= s3_side_r.last;
      out_data_r.stamp_seconds <= is_event ? s3_q_r : '0;
      out_data_r.stamp_micros  <= is_event ?
          teq_pkg::MICRO_W'(teq_pkg::MICRO_W'(s3_rem_r) *
                            teq_pkg::MICRO_W'(teq_pkg::TICKS_PER_SEC)) : '0;
      out_data_r.out_type      <= is_event ? s3_type_r : '0;
      out_data_r.out_code      <= is_event ? s3_code_r : '0;
      out_data_r.out_value     <= is_event ? s3_value_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/timestamped_event_queue.sv
// timestamped event queue: per-device circular event queues with drop on full
//
// requests enter on in_valid/in_ready with in_data (push, read or poll for one
// device); results leave on out_valid/out_ready with out_data, last marking the
// final result of each request. push, poll and every failing request give one
// result; a read gives one result per drained event, oldest first
// the first result passes through the command queue, then the memory read issued
// as it leaves the queue, then seconds multiply, remainder and output register
// while a read drains and no result is refused, the back part issues one event
// per cycle, set by the single read port of the event memory; other requests go
// at one a cycle unless stalled; a push waits at in_ready while earlier read requests
// still have memory reads to issue, so a slot is never reused before it has been read
// a queue holds at most QUEUE_DEPTH-1 events; a push to a full queue is dropped
// reset empties every queue by clearing its pointers; the event memory is not
// cleared and needs no clearing pass, so requests are taken right after reset
// a refused result freezes the back pipeline in place; the two-entry command
// queue then fills and in_ready falls until the receiver takes results again
module timestamped_event_queue #(
  parameter int QUEUE_DEPTH  = 128,
  parameter int DEVICE_COUNT = 2,
  parameter int MAX_READ     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  teq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output teq_pkg::out_item_t out_data
);

  localparam int AW = $clog2(DEVICE_COUNT * QUEUE_DEPTH);

  // front to command queue
  logic          cmd_push;
  teq_pkg::cmd_t cmd_data;
  logic          cmd_full;

  // command queue to back
  logic          head_valid;
  teq_pkg::cmd_t head;
  logic          pop;

  // back reports a drain whose reads have all been issued
  logic read_done;

  // event memory ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  teq_pkg::entry_t ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  teq_pkg::entry_t ram_rdata;

  teq_front #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .DEVICE_COUNT (DEVICE_COUNT),
    .MAX_READ     (MAX_READ)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data),
    .cmd_full  (cmd_full),
    .read_done (read_done),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  teq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  (cmd_data),
    .full       (cmd_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // stamp, kind and value of each event share one memory word
  teq_ram #(
    .WIDTH ($bits(teq_pkg::entry_t)),
    .DEPTH (DEVICE_COUNT * QUEUE_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  teq_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .DEVICE_COUNT (DEVICE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .read_done  (read_done),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### rtl/core/teq_checker.sv
// port checker for the timestamped event queue, bound to the top level
`include "timestamped_event_queue_defines.svh"

module teq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input teq_pkg::out_item_t out_data
);

  `TEQ_ASSERT_NEXT(a_out_valid_held, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `TEQ_ASSERT_NEXT(a_out_data_held, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
  `TEQ_ASSERT_NOW(a_status_only_single, out_valid && (out_data.status != teq_pkg::ST_EVENT), out_data.last && (out_data.stamp_seconds == '0) && (out_data.stamp_micros == '0) && (out_data.out_type == '0) && (out_data.out_code == '0) && (out_data.out_value == '0), "status result not single or not cleared")
  `TEQ_ASSERT_NOW(a_stamp_range, out_valid && (out_data.status == teq_pkg::ST_EVENT), (out_data.stamp_micros <= 20'd999000) && (out_data.stamp_seconds <= 23'd4294967), "stamp conversion out of range")
  `TEQ_ASSERT_AFTER_RESET(a_reset_quiet, !out_valid, "result shown after reset")

endmodule

bind timestamped_event_queue teq_checker u_teq_checker (.*);
